@@ src/wmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_pkg
// shared types, constants and key function of the window median filter
// ----------------------------------------------------------------------------
package wmf_pkg;
  localparam int MaxWidth   = 1024;
  localparam int MaxRadius  = 2;
  localparam int MaxHeight  = 4096;
  localparam int RingLines  = 2 * MaxRadius + 2;
  localparam int WinSide    = 2 * MaxRadius + 1;
  localparam int WinSize    = WinSide * WinSide;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int RingW      = $clog2(RingLines);
  localparam int StoreDepth = RingLines * MaxWidth;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int WinIdxW    = $clog2(WinSize + 1);
  localparam int PixW       = 24;
  localparam int PaddrW     = 4;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;
  localparam logic [1:0] RegGray   = 2'd3;

  localparam logic ReqPixel = 1'b0;
  localparam logic ReqDrain = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [PixW-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0] median_pixel;
    logic            end_of_line;
    logic            end_of_frame;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_READ, ST_RANK, ST_SEL, ST_OUT
  } wmf_state_t;

  typedef struct packed {
    logic start;      // latch item, write pixel
    logic check;      // evaluate window ready
    logic read;       // issue a read / collect
    logic rank;       // rank one candidate
    logic emit;       // load output register
  } wmf_cmd_t;

  typedef struct packed {
    logic ready_win;  // window complete
    logic read_done;
    logic rank_done;
    logic out_busy;
  } wmf_sts_t;

  function automatic logic [7:0] key_of(input logic [PixW-1:0] p, input logic gray);
    logic [12:0] s;
    s = 13'd11 * 13'(p[23:16]) + 13'd16 * 13'(p[15:8]) + 13'd5 * 13'(p[7:0]);
    key_of = gray ? p[7:0] : s[12:5];
  endfunction
endpackage

@@ src/wmf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_ram
// simple dual port generic ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/wmf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_ctrl
// sequencer of the window median filter
// ----------------------------------------------------------------------------
module wmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  wmf_pkg::wmf_sts_t sts,
  output wmf_pkg::wmf_cmd_t cmd,
  output logic              busy
);
  import wmf_pkg::*;
  wmf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_next = sts.ready_win ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (sts.read_done) begin
          state_next = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.rank = 1'b1;
        if (sts.rank_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ src/wmf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_datapath
// counters, line store, window gather and rank search
// ----------------------------------------------------------------------------
module wmf_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  wmf_pkg::wmf_cmd_t     cmd,
  output wmf_pkg::wmf_sts_t     sts,
  input  wmf_pkg::in_word_t     in_word,
  input  logic                  cfg_restart,
  input  logic [10:0]           image_width,
  input  logic [12:0]           image_height,
  input  logic [1:0]            window_radius,
  input  logic                  gray_mode,
  output wmf_pkg::out_word_t    out_word,
  output logic                  out_valid,
  input  logic                  out_ready
);
  import wmf_pkg::*;

  logic [ColW:0] w_eff;
  logic [RowW:0] h_eff;
  logic [1:0]    r_eff;
  always_comb begin
    w_eff = (image_width == '0) ? (ColW+1)'(1)
          : (image_width > 11'(MaxWidth)) ? (ColW+1)'(MaxWidth) : (ColW+1)'(image_width);
    h_eff = (image_height == '0) ? (RowW+1)'(1)
          : (image_height > 13'(MaxHeight)) ? (RowW+1)'(MaxHeight) : (RowW+1)'(image_height);
    r_eff = (window_radius > 2'(MaxRadius)) ? 2'(MaxRadius) : window_radius;
  end

  logic [ColW-1:0] in_column, out_column;
  logic [RowW:0]   in_row, out_row;
  logic [RingW-1:0] in_ring, out_ring;

  // line store
  logic                 we;
  logic [StoreAw-1:0]   waddr, raddr;
  logic [PixW-1:0]      rdata;
  wmf_ram #(.Width(PixW), .Depth(StoreDepth)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_word.pixel_value),
    .raddr(raddr), .rdata(rdata)
  );

  logic pix_ok;
  assign pix_ok = (in_word.req_type == ReqPixel) && (in_row < h_eff);
  assign we     = cmd.start && pix_ok;
  assign waddr  = StoreAw'({in_ring, in_column});

  // window bounds
  logic [RowW:0]  need_row, y0;
  logic [ColW:0]  need_col, x0;
  logic [RowW+1:0] nr_raw;
  logic [ColW+1:0] nc_raw;
  logic [RingW-1:0] y0_ring;
  always_comb begin
    nr_raw = (RowW+2)'(out_row) + (RowW+2)'(r_eff);
    nc_raw = (ColW+2)'(out_column) + (ColW+2)'(r_eff);
    need_row = (nr_raw > (RowW+2)'(h_eff - 1'b1)) ? h_eff - 1'b1 : (RowW+1)'(nr_raw);
    need_col = (nc_raw > (ColW+2)'(w_eff - 1'b1)) ? w_eff - 1'b1 : (ColW+1)'(nc_raw);
    y0 = (out_row >= (RowW+1)'(r_eff)) ? out_row - (RowW+1)'(r_eff) : '0;
    x0 = ((ColW+1)'(out_column) >= (ColW+1)'(r_eff))
       ? (ColW+1)'(out_column) - (ColW+1)'(r_eff) : '0;
    // ring line of the top window row
    if (out_row < (RowW+1)'(r_eff)) begin
      y0_ring = '0;
    end else if (out_ring >= RingW'(r_eff)) begin
      y0_ring = out_ring - RingW'(r_eff);
    end else begin
      y0_ring = out_ring + RingW'(RingLines) - RingW'(r_eff);
    end
  end

  // gather sweep
  logic [RowW:0]   gy;
  logic [ColW:0]   gx;
  logic [RingW-1:0] gring;
  logic            rd_pend;
  logic            gather_end;
  logic [PixW-1:0] win [WinSize];
  logic [WinIdxW-1:0] n_cnt;
  logic [WinIdxW-1:0] ci, cj;
  logic [WinIdxW-1:0] rank_cnt;
  logic [PixW-1:0] sel;
  logic            found;

  assign raddr = StoreAw'({gring, gx[ColW-1:0]});

  logic [7:0] ki, kj;
  assign ki = key_of(win[ci[$clog2(WinSize)-1:0]], gray_mode);
  assign kj = key_of(win[cj[$clog2(WinSize)-1:0]], gray_mode);

  always_comb begin
    sts.ready_win = (out_row < h_eff) &&
      ((in_row > need_row) ||
       (in_row == need_row && (ColW+1)'(in_column) > need_col));
    sts.read_done = gather_end && !rd_pend;
    sts.rank_done = found || (ci == n_cnt);
    sts.out_busy  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      in_ring   <= '0;
      out_column <= '0;
      out_row   <= '0;
      out_ring  <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      gather_end <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_restart) begin
        in_column <= '0; in_row <= '0; in_ring <= '0;
        out_column <= '0; out_row <= '0; out_ring <= '0;
      end else if (we) begin
        if ((ColW+1)'(in_column) + 1'b1 >= w_eff) begin
          in_column <= '0;
          in_row <= in_row + 1'b1;
          in_ring <= (in_ring == RingW'(RingLines-1)) ? '0 : in_ring + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
      end else if (cmd.emit) begin
        if ((ColW+1)'(out_column) + 1'b1 >= w_eff) begin
          out_column <= '0;
          if (out_row + 1'b1 >= h_eff) begin
            out_row <= '0; out_ring <= '0; in_row <= '0; in_column <= '0; in_ring <= '0;
          end else begin
            out_row <= out_row + 1'b1;
            out_ring <= (out_ring == RingW'(RingLines-1)) ? '0 : out_ring + 1'b1;
          end
        end else begin
          out_column <= out_column + 1'b1;
        end
      end
      if (cmd.check) begin
        gy <= y0;
        gx <= x0;
        gring <= y0_ring;
        n_cnt <= '0;
        rd_pend <= 1'b0;
        gather_end <= 1'b0;
        ci <= '0; cj <= '0; rank_cnt <= '0; found <= 1'b0;
      end
      if (cmd.read) begin
        rd_pend <= !gather_end;
        if (rd_pend) begin
          win[n_cnt[$clog2(WinSize)-1:0]] <= rdata;
          n_cnt <= n_cnt + 1'b1;
        end
        if (!gather_end) begin
          if (gx == need_col) begin
            gx <= x0;
            if (gy == need_row) begin
              gather_end <= 1'b1;
            end else begin
              gy <= gy + 1'b1;
              gring <= (gring == RingW'(RingLines-1)) ? '0 : gring + 1'b1;
            end
          end else begin
            gx <= gx + 1'b1;
          end
        end
      end
      if (cmd.rank && !sts.rank_done) begin
        if (cj == n_cnt) begin
          if (rank_cnt == (n_cnt >> 1)) begin
            found <= 1'b1;
            sel <= win[ci[$clog2(WinSize)-1:0]];
          end else begin
            ci <= ci + 1'b1;
          end
          cj <= '0;
          rank_cnt <= '0;
        end else begin
          if (kj < ki || (kj == ki && cj < ci)) begin
            rank_cnt <= rank_cnt + 1'b1;
          end
          cj <= cj + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_word.median_pixel <= gray_mode ? {16'd0, (found ? sel[7:0] : win[0][7:0])}
                                           : (found ? sel : win[0]);
        out_word.end_of_line <= ((ColW+1)'(out_column) == w_eff - 1'b1);
        out_word.end_of_frame <= ((ColW+1)'(out_column) == w_eff - 1'b1) &&
                                 (out_row == h_eff - 1'b1);
      end
    end
  end
endmodule

@@ src/window_median_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_filter_top
// 2-d median filter over a raster pixel stream with apb register port
// ----------------------------------------------------------------------------
// channel  | signals                         | payload
// in       | in_valid, in_ready              | in_word_t
// out      | out_valid, out_ready            | out_word_t
// cfg      | psel penable pwrite paddr pwdata| 32-bit registers
//
// one item at a time: an item with no result returns to idle after the window
// check, otherwise n window pixels are gathered through the single line store
// read port, then ranked by a serial search, and the result is loaded into
// the output word once the output register is free
// a finished word waits in the output register; the next item is taken then
// reset is synchronous; line store contents are not cleared
module window_median_filter_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wmf_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output wmf_pkg::out_word_t  out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [wmf_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wmf_pkg::*;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  window_radius;
  logic        gray_mode;
  logic        wr, restart, busy, in_fire;
  logic [1:0]  idx;
  wmf_cmd_t    cmd;
  wmf_sts_t    sts;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];
  assign restart = wr && (idx == RegWidth || idx == RegHeight || idx == RegRadius);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      image_height <= 13'd1024;
      window_radius <= 2'd1;
      gray_mode <= 1'b0;
    end else if (wr) begin
      case (idx)
        RegWidth:  image_width <= pwdata[10:0];
        RegHeight: image_height <= pwdata[12:0];
        RegRadius: window_radius <= pwdata[1:0];
        RegGray:   gray_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegWidth:  prdata = {21'd0, image_width};
      RegHeight: prdata = {19'd0, image_height};
      RegRadius: prdata = {30'd0, window_radius};
      RegGray:   prdata = {31'd0, gray_mode};
      default:   prdata = '0;
    endcase
  end

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;

  wmf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .sts(sts), .cmd(cmd), .busy(busy)
  );

  wmf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_word(in_word),
    .cfg_restart(restart), .image_width(image_width), .image_height(image_height),
    .window_radius(window_radius), .gray_mode(gray_mode),
    .out_word(out_word), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule

@@ src/wmf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_checker
// port level checks of the window median filter
// ----------------------------------------------------------------------------
module wmf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input wmf_pkg::out_word_t out_word,
  input logic               pready
);
  import wmf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word dropped while stalled");

  a_frame_eol: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.end_of_frame |-> out_word.end_of_line)
    else $error("frame end without line end");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind window_median_filter_top wmf_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
  .pready(pready)
);
